// ----- hw/rtl/mlt_pkg.sv -----
// shared types, constants and hash helper for the mac learning table
package mlt_pkg;

    // table geometry
    localparam int BUCKETS = 20;
    localparam int WAYS    = 4;
    localparam int ENTRIES = BUCKETS * WAYS;
    localparam int ROW_W   = $clog2(BUCKETS);
    localparam int SWEEP_W = $clog2(BUCKETS + 1);

    // field widths
    localparam int MAC_W    = 48;
    localparam int VLAN_W   = 12;
    localparam int PORT_W   = 5;
    localparam int STAMP_W  = 32;
    localparam int AGE_W    = 16;
    localparam int CNT_W    = 7;
    localparam int STATUS_W = 3;
    localparam int BUCKET_W = 5;
    localparam int HASH_W   = 24;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_VLAN = 1'd1;
    localparam logic [AGE_W-1:0]     AGE_LIMIT_RST    = 16'd300;
    localparam logic [VLAN_W-1:0]    DEFAULT_VLAN_RST = 12'd1;

    // reciprocals for the hash residues, floor(2^24 / d)
    localparam int QUOT_W = 20;
    localparam logic [QUOT_W-1:0] RECIP19 = 20'(2**HASH_W / 19);
    localparam logic [QUOT_W-1:0] RECIP20 = 20'(2**HASH_W / 20);

    typedef enum logic [1:0] {
        ACT_LEARN = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_PURGE = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_REFRESHED = 3'd0,
        ST_ADDED     = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_TICK_DONE = 3'd3,
        ST_PURGED    = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [MAC_W-1:0]  src_mac;
        logic              vlan_tagged;
        logic [VLAN_W-1:0] vlan_id;
        logic [PORT_W-1:0] ingress_port;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BUCKET_W-1:0] bucket;
        logic [CNT_W-1:0]    removed_count;
        logic [CNT_W-1:0]    entry_count;
    } result_t;

    typedef struct packed {
        logic [MAC_W-1:0]   mac;
        logic [VLAN_W-1:0]  vlan;
        logic [PORT_W-1:0]  port;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef entry_t [WAYS-1:0] row_t;

    // bucket = floor(319*a/19) mod 20, rebuilt from a mod 19 and a mod 20:
    // with p = 319*a it reduces to ((15*(a mod 19)) mod 19 + a mod 20) mod 20
    function automatic logic [BUCKET_W-1:0] bucket_of(logic [4:0] rem19, logic [4:0] rem20);
        logic [4:0] scaled;
        logic [5:0] sum;
        unique case (rem19)
            5'd0:    scaled = 5'd0;
            5'd1:    scaled = 5'd15;
            5'd2:    scaled = 5'd11;
            5'd3:    scaled = 5'd7;
            5'd4:    scaled = 5'd3;
            5'd5:    scaled = 5'd18;
            5'd6:    scaled = 5'd14;
            5'd7:    scaled = 5'd10;
            5'd8:    scaled = 5'd6;
            5'd9:    scaled = 5'd2;
            5'd10:   scaled = 5'd17;
            5'd11:   scaled = 5'd13;
            5'd12:   scaled = 5'd9;
            5'd13:   scaled = 5'd5;
            5'd14:   scaled = 5'd1;
            5'd15:   scaled = 5'd16;
            5'd16:   scaled = 5'd12;
            5'd17:   scaled = 5'd8;
            5'd18:   scaled = 5'd4;
            default: scaled = 5'd0;
        endcase
        sum = {1'b0, scaled} + {1'b0, rem20};
        if (sum >= 6'd20)
        begin
            sum = sum - 6'd20;
        end
        return BUCKET_W'(sum);
    endfunction

endpackage

// ----- hw/rtl/mac_learning_table_with_aging_core.sv -----
// source address learning table with aging, bucket rows held in one synchronous ram
//
// A command is taken when start is high and busy is low; its single result appears on
// result with done high for exactly one cycle and cannot be held off. A learn holds busy
// through the quotient and residue steps, the row read and the match and write-back, and
// its result shows once it is idle again. A tick or a reserved action answers on the next
// cycle without raising busy. A purge sweeps the row ram one bucket row per cycle, holding
// busy to the last row. The table comes out of reset empty. The user writes age_limit and
// default_vlan through cfg_we/cfg_index/cfg_data while idle, which is not enforced.
module mac_learning_table_with_aging_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  mlt_pkg::item_t                   cmd,
    output logic                             done,
    output mlt_pkg::result_t                 result,
    input  logic                             cfg_we,
    input  logic [mlt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mlt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mlt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH1,
        S_HASH2,
        S_LEARN,
        S_PURGE
    } state_t;

    state_t                          state_reg,        state_next;
    item_t                           cmd_reg,          cmd_next;
    logic [QUOT_W-1:0]               q19_reg,          q19_next;
    logic [QUOT_W-1:0]               q20_reg,          q20_next;
    logic [BUCKET_W-1:0]             bucket_reg,       bucket_next;
    logic [SWEEP_W-1:0]              row_reg,          row_next;
    logic [CNT_W-1:0]                removed_reg,      removed_next;
    logic [CNT_W-1:0]                total_reg,        total_next;
    logic [STAMP_W-1:0]              seconds_reg,      seconds_next;
    logic [AGE_W-1:0]                age_limit_reg,    age_limit_next;
    logic [VLAN_W-1:0]               default_vlan_reg, default_vlan_next;
    logic [BUCKETS-1:0][WAYS-1:0]    valid_reg,        valid_next;
    logic                            done_reg,         done_next;
    result_t                         result_reg,       result_next;

    // row ram and its port
    row_t                            row_mem [BUCKETS];
    row_t                            rd_row_reg;
    logic                            rd_en;
    logic [ROW_W-1:0]                rd_addr;
    logic                            wr_en;
    logic [ROW_W-1:0]                wr_addr;
    row_t                            wr_row;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // next state and datapath
    always_comb
    begin
        logic [HASH_W-1:0]       low;
        logic [HASH_W+QUOT_W-1:0] prod19;
        logic [HASH_W+QUOT_W-1:0] prod20;
        logic [HASH_W-1:0]       diff19;
        logic [HASH_W-1:0]       diff20;
        logic [5:0]              r19;
        logic [5:0]              r20;
        logic [WAYS-1:0]         vrow;
        logic [WAYS-1:0]         match;
        logic [WAYS-1:0]         free_oh;
        logic [WAYS-1:0]         aged;
        logic                    hit;
        logic [ROW_W-1:0]        proc_row;
        logic [STAMP_W-1:0]      age;
        logic [VLAN_W-1:0]       new_vlan;

        state_next        = state_reg;
        cmd_next          = cmd_reg;
        q19_next          = q19_reg;
        q20_next          = q20_reg;
        bucket_next       = bucket_reg;
        row_next          = row_reg;
        removed_next      = removed_reg;
        total_next        = total_reg;
        seconds_next      = seconds_reg;
        age_limit_next    = age_limit_reg;
        default_vlan_next = default_vlan_reg;
        valid_next        = valid_reg;
        done_next         = 1'b0;
        result_next       = result_reg;
        rd_en             = 1'b0;
        rd_addr           = '0;
        wr_en             = 1'b0;
        wr_addr           = bucket_reg;
        wr_row            = rd_row_reg;

        low      = cmd_reg.src_mac[HASH_W-1:0];
        prod19   = (HASH_W+QUOT_W)'(low) * (HASH_W+QUOT_W)'(RECIP19);
        prod20   = (HASH_W+QUOT_W)'(low) * (HASH_W+QUOT_W)'(RECIP20);
        diff19   = low - HASH_W'(q19_reg * 5'd19);
        diff20   = low - HASH_W'(q20_reg * 5'd20);
        r19      = (diff19[5:0] >= 6'd19) ? (diff19[5:0] - 6'd19) : diff19[5:0];
        r20      = (diff20[5:0] >= 6'd20) ? (diff20[5:0] - 6'd20) : diff20[5:0];
        proc_row = ROW_W'(row_reg - SWEEP_W'(1));
        new_vlan = cmd_reg.vlan_tagged ? cmd_reg.vlan_id : default_vlan_reg;
        vrow     = '0;
        match    = '0;
        free_oh  = '0;
        aged     = '0;
        hit      = 1'b0;
        age      = '0;

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AGE_LIMIT:    age_limit_next    = cfg_data;
                REG_DEFAULT_VLAN: default_vlan_next = cfg_data[VLAN_W-1:0];
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    unique case (cmd.action)
                        ACT_LEARN:
                        begin
                            state_next = S_HASH1;
                        end
                        ACT_PURGE:
                        begin
                            row_next     = '0;
                            removed_next = '0;
                            state_next   = S_PURGE;
                        end
                        ACT_TICK:
                        begin
                            seconds_next = seconds_reg + STAMP_W'(1);
                            done_next    = 1'b1;
                            result_next  = '{ST_TICK_DONE, '0, '0, total_reg};
                        end
                        default:
                        begin
                            // reserved action: no change, answers as a tick
                            done_next   = 1'b1;
                            result_next = '{ST_TICK_DONE, '0, '0, total_reg};
                        end
                    endcase
                end
            end

            // quotients by reciprocal, at most one short
            S_HASH1:
            begin
                q19_next   = prod19[HASH_W+QUOT_W-1:HASH_W];
                q20_next   = prod20[HASH_W+QUOT_W-1:HASH_W];
                state_next = S_HASH2;
            end

            // residues, bucket and row read
            S_HASH2:
            begin
                bucket_next = bucket_of(r19[4:0], r20[4:0]);
                rd_en       = 1'b1;
                rd_addr     = ROW_W'(bucket_next);
                state_next  = S_LEARN;
            end

            // match, pick free way and write the row back
            S_LEARN:
            begin
                vrow    = valid_reg[bucket_reg];
                for (int w = 0; w < WAYS; w++)
                begin
                    match[w] = vrow[w] && (rd_row_reg[w].mac == cmd_reg.src_mac);
                end
                hit     = |match;
                free_oh = ~vrow & (vrow + WAYS'(1));
                for (int w = 0; w < WAYS; w++)
                begin
                    if (match[w])
                    begin
                        wr_row[w].stamp = seconds_reg;
                    end
                    else if (!hit && free_oh[w])
                    begin
                        wr_row[w] = '{cmd_reg.src_mac, new_vlan, cmd_reg.ingress_port,
                                      seconds_reg};
                    end
                end
                wr_en      = hit || (|free_oh);
                done_next  = 1'b1;
                state_next = S_IDLE;
                priority if (hit)
                begin
                    result_next = '{ST_REFRESHED, bucket_reg, '0, total_reg};
                end
                else if (|free_oh)
                begin
                    valid_next[bucket_reg] = vrow | free_oh;
                    total_next             = total_reg + CNT_W'(1);
                    result_next            = '{ST_ADDED, bucket_reg, '0, total_next};
                end
                else
                begin
                    result_next = '{ST_DROPPED, bucket_reg, '0, total_reg};
                end
            end

            // sweep: read row n while checking row n-1
            S_PURGE:
            begin
                if (row_reg < SWEEP_W'(BUCKETS))
                begin
                    rd_en   = 1'b1;
                    rd_addr = row_reg[ROW_W-1:0];
                end
                if (row_reg != '0)
                begin
                    vrow = valid_reg[proc_row];
                    for (int w = 0; w < WAYS; w++)
                    begin
                        age     = seconds_reg - rd_row_reg[w].stamp;
                        aged[w] = vrow[w] && (age > STAMP_W'(age_limit_reg));
                    end
                    valid_next[proc_row] = vrow & ~aged;
                    removed_next         = removed_reg + CNT_W'($countones(aged));
                end
                if (row_reg == SWEEP_W'(BUCKETS))
                begin
                    total_next  = total_reg - removed_next;
                    done_next   = 1'b1;
                    result_next = '{ST_PURGED, '0, removed_next, total_next};
                    state_next  = S_IDLE;
                end
                else
                begin
                    row_next = row_reg + SWEEP_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            row_reg          <= '0;
            removed_reg      <= '0;
            total_reg        <= '0;
            seconds_reg      <= '0;
            age_limit_reg    <= AGE_LIMIT_RST;
            default_vlan_reg <= DEFAULT_VLAN_RST;
            valid_reg        <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            row_reg          <= row_next;
            removed_reg      <= removed_next;
            total_reg        <= total_next;
            seconds_reg      <= seconds_next;
            age_limit_reg    <= age_limit_next;
            default_vlan_reg <= default_vlan_next;
            valid_reg        <= valid_next;
            done_reg         <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        q19_reg    <= q19_next;
        q20_reg    <= q20_next;
        bucket_reg <= bucket_next;
        result_reg <= result_next;
    end

    // bucket row ram, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_row_reg <= row_mem[rd_addr];
        end
    end

    // a result never overlaps a command in progress
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // running count agrees with the valid bits whenever idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(valid_reg) == int'(total_reg)))
        else $error("entry count out of step with valid bits");

    // a learn answers with done after its transfer, once the hash and learn states are through
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.action == ACT_LEARN)) |=> ##3 done)
        else $error("learn result late or missing");

    // a tick advances the seconds counter by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.action == ACT_TICK))
            |=> (done && (seconds_reg == $past(seconds_reg) + STAMP_W'(1))))
        else $error("tick did not advance time");

    // the table never reports more entries than it holds
    assert property (@(posedge clk) disable iff (!rst_n) total_reg <= CNT_W'(ENTRIES))
        else $error("entry count above table size");

endmodule
